// File: rtl/core/gcr_floppy_track_encoder_unit_assert.svh
// ---------------------------------------------------------------------------
// gcr track encoder assertion macros
// shared property wrappers, clocked on clk and disabled during rst
// ---------------------------------------------------------------------------
`ifndef GCR_FLOPPY_TRACK_ENCODER_UNIT_ASSERT_SVH
`define GCR_FLOPPY_TRACK_ENCODER_UNIT_ASSERT_SVH

// same-cycle implication
`define GCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/gcr_pkg.sv
// ---------------------------------------------------------------------------
// gcr_pkg
// types, constants and tables shared by the gcr track encoder modules
// ---------------------------------------------------------------------------
`default_nettype none

package gcr_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hff;
  localparam logic [7:0] GAP_BYTE  = 8'h55;
  localparam logic [7:0] HDR_MARK  = 8'h08;
  localparam logic [7:0] DATA_MARK = 8'h07;
  localparam logic [7:0] HDR_PAD   = 8'h0f;

  // register indexes of the write port
  localparam logic [1:0] REG_TRACK = 2'd0;
  localparam logic [1:0] REG_ID_A  = 2'd1;
  localparam logic [1:0] REG_ID_B  = 2'd2;

  localparam int unsigned GROUP_LEN = 5;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_W    = 2;
  localparam int unsigned QCNT_W    = 3;

  typedef enum logic [1:0] {
    CMD_PREAMBLE,
    CMD_GROUP,
    CMD_FINAL
  } cmd_kind_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SYNC_A,
    PH_HDR_A,
    PH_HDR_B,
    PH_GAP_A,
    PH_SYNC_B,
    PH_DATA,
    PH_GAP_B
  } phase_t;

  // one command from front to back; for a preamble the bytes are
  // sector, track, id a, id b
  typedef struct packed {
    cmd_kind_t       kind;
    logic [2:0]      zone;
    logic            end_track;
    logic [3:0][7:0] b;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  function automatic logic [4:0] gcr_nibble(input logic [3:0] n);
    logic [4:0] c;
    unique case (n)
      4'h0: c = 5'h0a;
      4'h1: c = 5'h0b;
      4'h2: c = 5'h12;
      4'h3: c = 5'h13;
      4'h4: c = 5'h0e;
      4'h5: c = 5'h0f;
      4'h6: c = 5'h16;
      4'h7: c = 5'h17;
      4'h8: c = 5'h09;
      4'h9: c = 5'h19;
      4'ha: c = 5'h1a;
      4'hb: c = 5'h1b;
      4'hc: c = 5'h0d;
      4'hd: c = 5'h1d;
      4'he: c = 5'h1e;
      4'hf: c = 5'h15;
      default: c = 5'h0a;
    endcase
    return c;
  endfunction

  // four bytes, first in b[0], to forty code bits, first byte at the top
  function automatic logic [39:0] gcr_encode(input logic [3:0][7:0] v);
    logic [39:0] acc;
    acc = '0;
    for (int i = 0; i < 4; i++) begin
      acc[39-10*i -: 10] = {gcr_nibble(v[i][7:4]), gcr_nibble(v[i][3:0])};
    end
    return acc;
  endfunction

  function automatic logic [4:0] zone_sectors(input logic [2:0] z);
    logic [4:0] s;
    unique case (z)
      3'd0:    s = 5'd21;
      3'd1:    s = 5'd19;
      3'd2:    s = 5'd18;
      default: s = 5'd17;
    endcase
    return s;
  endfunction

  function automatic logic [4:0] zone_gap2(input logic [2:0] z);
    logic [4:0] g;
    unique case (z)
      3'd0:    g = 5'd12;
      3'd1:    g = 5'd21;
      3'd2:    g = 5'd16;
      default: g = 5'd13;
    endcase
    return g;
  endfunction

  function automatic logic [12:0] zone_length(input logic [2:0] z);
    logic [12:0] l;
    unique case (z)
      3'd0:    l = 13'd7696;
      3'd1:    l = 13'd7142;
      3'd2:    l = 13'd6666;
      default: l = 13'd6250;
    endcase
    return l;
  endfunction

  function automatic logic [1:0] zone_speed(input logic [2:0] z);
    logic [1:0] s;
    if (z == 3'd4) begin
      s = 2'd0;
    end else begin
      s = z[1:0] ^ 2'd3;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/gcr_front.sv
// ---------------------------------------------------------------------------
// gcr_front
// holds config and track position, turns the data bytes of a sector into commands
// ---------------------------------------------------------------------------
`default_nettype none

module gcr_front #(
  parameter int unsigned MAX_TRACK = 42
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        accept,
  input  wire logic [7:0]  data_byte,
  output gcr_pkg::cmd_t    cmd,
  output logic             push
);

  logic [5:0] track_number;
  logic [7:0] header_id_a;
  logic [7:0] header_id_b;
  logic [4:0] sector_index;
  logic [7:0] byte_index;
  logic [7:0] data_checksum;
  logic [7:0] pending [3];

  logic [5:0] trk_clamped;
  logic [2:0] zone;
  logic [1:0] pos;
  logic       wrap;
  logic [7:0] chk_next;

  always_comb begin
    trk_clamped = (track_number > 6'(MAX_TRACK)) ? 6'(MAX_TRACK) : track_number;
    priority if (trk_clamped <= 6'd17) begin
      zone = 3'd0;
    end else if (trk_clamped <= 6'd24) begin
      zone = 3'd1;
    end else if (trk_clamped <= 6'd30) begin
      zone = 3'd2;
    end else if (trk_clamped <= 6'd35) begin
      zone = 3'd3;
    end else begin
      zone = 3'd4;
    end
  end

  assign pos      = 2'(byte_index - 8'd3);
  assign wrap     = ({1'b0, sector_index} + 6'd1) >= {1'b0, gcr_pkg::zone_sectors(zone)};
  assign chk_next = data_checksum ^ data_byte;

  // classify the byte
  always_comb begin
    cmd.kind      = gcr_pkg::CMD_GROUP;
    cmd.zone      = zone;
    cmd.end_track = 1'b0;
    cmd.b         = '0;
    push          = 1'b0;
    priority if (byte_index == 8'd0) begin
      push      = accept;
      cmd.kind  = gcr_pkg::CMD_PREAMBLE;
      cmd.b[0]  = {3'd0, sector_index};
      cmd.b[1]  = {2'd0, track_number};
      cmd.b[2]  = header_id_a;
      cmd.b[3]  = header_id_b;
    end else if (byte_index == 8'd1) begin
      push = 1'b0;
    end else if (byte_index == 8'd2) begin
      push     = accept;
      cmd.b[0] = gcr_pkg::DATA_MARK;
      cmd.b[1] = pending[0];
      cmd.b[2] = pending[1];
      cmd.b[3] = data_byte;
    end else if (byte_index == 8'd255) begin
      push          = accept;
      cmd.kind      = gcr_pkg::CMD_FINAL;
      cmd.end_track = wrap;
      cmd.b[0]      = data_byte;
      cmd.b[1]      = chk_next;
    end else if (pos == 2'd3) begin
      push     = accept;
      cmd.b[0] = pending[0];
      cmd.b[1] = pending[1];
      cmd.b[2] = pending[2];
      cmd.b[3] = data_byte;
    end else begin
      // byte only fills the group buffer
      push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      track_number  <= 6'd1;
      header_id_a   <= 8'd0;
      header_id_b   <= 8'd0;
      sector_index  <= 5'd0;
      byte_index    <= 8'd0;
      data_checksum <= 8'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          gcr_pkg::REG_TRACK: track_number <= cfg_data[5:0];
          gcr_pkg::REG_ID_A:  header_id_a  <= cfg_data;
          gcr_pkg::REG_ID_B:  header_id_b  <= cfg_data;
          default:   ;
        endcase
      end
      if (accept) begin
        byte_index <= byte_index + 8'd1;
        if (byte_index == 8'd0) begin
          data_checksum <= data_byte;
        end else begin
          data_checksum <= chk_next;
        end
        if (byte_index == 8'd255) begin
          sector_index <= wrap ? 5'd0 : sector_index + 5'd1;
        end
      end
    end
  end

  // group buffer, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      if (byte_index == 8'd0) begin
        pending[0] <= data_byte;
      end else if (byte_index == 8'd1) begin
        pending[1] <= data_byte;
      end else if (byte_index != 8'd2 && byte_index != 8'd255 && pos != 2'd3) begin
        pending[pos] <= data_byte;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/gcr_queue.sv
// ---------------------------------------------------------------------------
// gcr_queue
// small command fifo between front and back
// ---------------------------------------------------------------------------
`default_nettype none

module gcr_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire gcr_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output gcr_pkg::q_head_t   head,
  output logic               full
);

  gcr_pkg::cmd_t                   mem [gcr_pkg::QDEPTH];
  logic [gcr_pkg::QPTR_W-1:0]      wr_ptr;
  logic [gcr_pkg::QPTR_W-1:0]      rd_ptr;
  logic [gcr_pkg::QCNT_W-1:0]      count;

  assign full       = count == gcr_pkg::QCNT_W'(gcr_pkg::QDEPTH);
  assign head.valid = count != '0;
  assign head.cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/gcr_back.sv
// ---------------------------------------------------------------------------
// gcr_back
// expands commands into coded track bytes, one per cycle while m_tready does not stall, registered out
// ---------------------------------------------------------------------------
`default_nettype none

`include "gcr_floppy_track_encoder_unit_assert.svh"

module gcr_back #(
  parameter int unsigned SYNC_LENGTH       = 6,
  parameter int unsigned HEADER_GAP_LENGTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire gcr_pkg::q_head_t head,
  output logic                  pop,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [23:0]           m_tdata,
  output logic                  m_tlast,
  output logic [0:0]            m_tuser
);

  gcr_pkg::phase_t               phase;
  gcr_pkg::phase_t               phase_next;
  gcr_pkg::phase_t               succ;
  gcr_pkg::cmd_t                 cmd;
  logic [gcr_pkg::CNT_W-1:0]     cnt;
  logic [gcr_pkg::CNT_W-1:0]     run_len;
  logic                          phase_last;
  logic                          emit;
  logic                          is_last;
  logic [3:0][7:0]               grp;
  logic [39:0]                   code;
  logic [7:0]                    out_byte;
  logic [7:0]                    hdr_chk;

  assign emit = (phase != gcr_pkg::PH_IDLE) && (!m_tvalid || m_tready);

  always_comb begin
    unique case (phase)
      gcr_pkg::PH_SYNC_A, gcr_pkg::PH_SYNC_B:
        run_len = gcr_pkg::CNT_W'(SYNC_LENGTH);
      gcr_pkg::PH_GAP_A:
        run_len = gcr_pkg::CNT_W'(HEADER_GAP_LENGTH);
      gcr_pkg::PH_GAP_B:
        run_len = gcr_pkg::zone_gap2(cmd.zone);
      default:
        run_len = gcr_pkg::CNT_W'(gcr_pkg::GROUP_LEN);
    endcase
    phase_last = cnt == run_len - 1'b1;
  end

  // next state
  always_comb begin
    unique case (phase)
      gcr_pkg::PH_SYNC_A: succ = gcr_pkg::PH_HDR_A;
      gcr_pkg::PH_HDR_A:  succ = gcr_pkg::PH_HDR_B;
      gcr_pkg::PH_HDR_B:  succ = gcr_pkg::PH_GAP_A;
      gcr_pkg::PH_GAP_A:  succ = gcr_pkg::PH_SYNC_B;
      gcr_pkg::PH_DATA:
        succ = (cmd.kind == gcr_pkg::CMD_FINAL) ? gcr_pkg::PH_GAP_B : gcr_pkg::PH_IDLE;
      default:            succ = gcr_pkg::PH_IDLE;
    endcase
    is_last    = phase_last && succ == gcr_pkg::PH_IDLE;
    pop        = head.valid && (phase == gcr_pkg::PH_IDLE || (emit && is_last));
    phase_next = phase;
    if (pop) begin
      phase_next = (head.cmd.kind == gcr_pkg::CMD_PREAMBLE) ? gcr_pkg::PH_SYNC_A
                                                             : gcr_pkg::PH_DATA;
    end else if (emit && phase_last) begin
      phase_next = succ;
    end
  end

  // outputs
  always_comb begin
    hdr_chk = cmd.b[0] ^ cmd.b[1] ^ cmd.b[2] ^ cmd.b[3];
    unique case (phase)
      gcr_pkg::PH_HDR_A: begin
        grp[0] = gcr_pkg::HDR_MARK;
        grp[1] = hdr_chk;
        grp[2] = cmd.b[0];
        grp[3] = cmd.b[1];
      end
      gcr_pkg::PH_HDR_B: begin
        grp[0] = cmd.b[2];
        grp[1] = cmd.b[3];
        grp[2] = gcr_pkg::HDR_PAD;
        grp[3] = gcr_pkg::HDR_PAD;
      end
      default: grp = cmd.b;
    endcase
    code = gcr_pkg::gcr_encode(grp);
    unique case (phase)
      gcr_pkg::PH_SYNC_A, gcr_pkg::PH_SYNC_B: out_byte = gcr_pkg::SYNC_BYTE;
      gcr_pkg::PH_GAP_A, gcr_pkg::PH_GAP_B:   out_byte = gcr_pkg::GAP_BYTE;
      default: begin
        unique case (cnt[2:0])
          3'd0:    out_byte = code[39:32];
          3'd1:    out_byte = code[31:24];
          3'd2:    out_byte = code[23:16];
          3'd3:    out_byte = code[15:8];
          default: out_byte = code[7:0];
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= gcr_pkg::PH_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (pop || (emit && phase_last)) begin
        cnt <= '0;
      end else if (emit) begin
        cnt <= cnt + 1'b1;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= head.cmd;
    end
    if (emit) begin
      m_tdata <= {1'b0, gcr_pkg::zone_length(cmd.zone), gcr_pkg::zone_speed(cmd.zone),
                  out_byte};
      m_tlast    <= is_last;
      m_tuser[0] <= is_last && cmd.end_track;
    end
  end

  `GCR_ASSERT_NOW(a_cnt_in_run, phase != gcr_pkg::PH_IDLE, cnt < run_len, "run counter overran")
  `GCR_ASSERT_NEXT(a_preamble_start, pop && head.cmd.kind == gcr_pkg::CMD_PREAMBLE,
                   phase == gcr_pkg::PH_SYNC_A && cnt == '0, "preamble did not start on sync")
  `GCR_ASSERT_NOW(a_gap2_final, phase == gcr_pkg::PH_GAP_B, cmd.kind == gcr_pkg::CMD_FINAL,
                  "gap2 outside final group")
  `GCR_ASSERT_NOW(a_group_ends_data, emit && is_last && cmd.kind == gcr_pkg::CMD_GROUP,
                  phase == gcr_pkg::PH_DATA, "group ended outside data phase")

endmodule

`default_nettype wire

// File: rtl/core/gcr_floppy_track_encoder_unit.sv
// ---------------------------------------------------------------------------
// gcr_floppy_track_encoder_unit
// 4-to-5 gcr floppy track encoder: sector data bytes in, coded track out
// ---------------------------------------------------------------------------
//
//  channel  | direction | transaction carries
//  ---------+-----------+---------------------------------------------------
//  s_*      | in        | one sector data byte
//  m_*      | out       | one coded track byte, speed class, track length
//  cfg_*    | in        | register write: track number, id a, id b
//
//  a data byte is taken every cycle while the command queue has room; the
//  back end sends one coded byte per cycle, so the sustained rate is set by
//  the output side: about 1.4 output bytes per input, a 30-byte preamble on
//  the first byte of a sector and 5 plus gap2 bytes on the last one
//  reset is synchronous; there is no clearing pass
//  a stall on m_* fills the four-entry queue, then s_tready drops
//
`default_nettype none

module gcr_floppy_track_encoder_unit #(
  parameter int unsigned SYNC_LENGTH       = 6,
  parameter int unsigned HEADER_GAP_LENGTH = 8,
  parameter int unsigned MAX_TRACK         = 42
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [7:0] gcr_byte, [9:8] speed_class,
                                      // [22:10] track_length, [23] zero
  output logic             m_tlast,   // last_of_run
  output logic [0:0]       m_tuser    // [0] end_of_track
);

  logic              accept;
  logic              push;
  logic              pop;
  logic              full;
  gcr_pkg::cmd_t     cmd;
  gcr_pkg::q_head_t  head;

  // front takes a byte whenever the queue can hold its command
  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  gcr_front #(
    .MAX_TRACK (MAX_TRACK)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .data_byte (s_tdata),
    .cmd       (cmd),
    .push      (push)
  );

  // decouples classification from byte expansion
  gcr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (cmd),
    .pop      (pop),
    .head     (head),
    .full     (full)
  );

  // expands one command at a time, next command loads on the last byte
  gcr_back #(
    .SYNC_LENGTH       (SYNC_LENGTH),
    .HEADER_GAP_LENGTH (HEADER_GAP_LENGTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire
